// ===== sv/sos_pkg.sv =====
// Shared types and constants for the scan object segmenter.
package sos_pkg;

  localparam int DEF_MAX_OBJECTS = 20;
  localparam int DEF_MAX_RUN     = 128;

  localparam int RANGE_W = 10;
  localparam int ANGLE_W = 8;
  localparam int OBJ_W   = 5;
  localparam int CIDX_W  = 2;

  localparam logic [RANGE_W-1:0] RST_ENTER_LEVEL = 10'd80;
  localparam logic [RANGE_W-1:0] RST_EXIT_LEVEL  = 10'd100;
  localparam logic [RANGE_W-1:0] RST_AGREE_TOL   = 10'd6;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_ENTER = 2'd1,
    CFG_EXIT  = 2'd2,
    CFG_TOL   = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    MODE_THRESH = 1'b0,
    MODE_AGREE  = 1'b1
  } seg_mode_t;

endpackage

// ===== sv/scan_object_segmenter.sv =====
// Top level of the scan object segmenter: object detection and serial mean divider.
// Splits a scan into objects, one sample per input transfer. A sample that closes no
// object leaves the block idle, so the input stays ready. A sample that closes an
// object starts a restoring divider that produces one bit of the mean per cycle over
// the width of the range sum (SUM_W = clog2(MAX_RUN*1023+1) bits, 17 at the default
// MAX_RUN of 128) and then moves the result into the output register, so the input
// stalls through the division and the move, and longer while an earlier result still
// waits in the output register. The output register lets further samples in while a
// finished result waits to be taken.
// Configuration writes are always ready and should be issued while the block is idle.
module scan_object_segmenter #(
  parameter int MAX_OBJECTS = sos_pkg::DEF_MAX_OBJECTS,
  parameter int MAX_RUN     = sos_pkg::DEF_MAX_RUN
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // sample channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_sweep_start,
  input  logic [sos_pkg::RANGE_W-1:0]  in_ir_range,
  input  logic [sos_pkg::RANGE_W-1:0]  in_sonar_range,
  input  logic [sos_pkg::ANGLE_W-1:0]  in_angle,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sos_pkg::OBJ_W-1:0]    out_object_number,
  output logic [sos_pkg::ANGLE_W-1:0]  out_start_angle,
  output logic [sos_pkg::ANGLE_W-1:0]  out_end_angle,
  output logic [sos_pkg::RANGE_W-1:0]  out_mean_range,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sos_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [sos_pkg::RANGE_W-1:0]  cfg_data
);

  localparam int CNT_W   = $clog2(MAX_OBJECTS + 1);
  localparam int TALLY_W = $clog2(MAX_RUN + 1);
  localparam int SUM_W   = $clog2(MAX_RUN * 1023 + 1);
  localparam int DCNT_W  = $clog2(SUM_W + 1);
  localparam int RW      = sos_pkg::RANGE_W;
  localparam int AW      = sos_pkg::ANGLE_W;
  localparam int OW      = sos_pkg::OBJ_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t            state_r, state_nxt;

  // configuration
  logic              mode_r, mode_nxt;
  logic [RW-1:0]     enter_r, enter_nxt;
  logic [RW-1:0]     exit_r, exit_nxt;
  logic [RW-1:0]     tol_r, tol_nxt;

  // segmentation state
  logic              open_r, open_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic [AW-1:0]     open_ang_r, open_ang_nxt;
  logic [AW-1:0]     last_ang_r, last_ang_nxt;

  // result waiting for the divider
  logic [OW-1:0]     pend_obj_r, pend_obj_nxt;
  logic [AW-1:0]     pend_start_r, pend_start_nxt;
  logic [AW-1:0]     pend_end_r, pend_end_nxt;

  // serial divider
  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [TALLY_W-1:0] rem_r, rem_nxt;
  logic [TALLY_W-1:0] dsr_r, dsr_nxt;
  logic [RW-1:0]     quo_r, quo_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              dzero_r, dzero_nxt;

  // output register
  logic              ovld_r, ovld_nxt;
  logic [OW-1:0]     oobj_r, oobj_nxt;
  logic [AW-1:0]     ostart_r, ostart_nxt;
  logic [AW-1:0]     oend_r, oend_nxt;
  logic [RW-1:0]     omean_r, omean_nxt;

  logic              in_xfer;
  logic              out_xfer;
  logic [TALLY_W:0]  trial;
  logic              trial_ge;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = ovld_r && !out_stall;

  assign out_valid         = ovld_r;
  assign out_object_number = oobj_r;
  assign out_start_angle   = ostart_r;
  assign out_end_angle     = oend_r;
  assign out_mean_range    = omean_r;

  // one restoring step: bring down the next dividend bit
  assign trial    = {rem_r, dvd_r[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, dsr_r});

  always_comb begin
    logic             open0, open1, open2;
    logic [CNT_W-1:0] cnt0, cnt1;
    logic [SUM_W-1:0] sum1;
    logic [TALLY_W-1:0] tally1;
    logic [RW-1:0]    diff;
    logic             want_open, want_close, do_open, closed;

    state_nxt      = state_r;
    mode_nxt       = mode_r;
    enter_nxt      = enter_r;
    exit_nxt       = exit_r;
    tol_nxt        = tol_r;
    open_nxt       = open_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    tally_nxt      = tally_r;
    open_ang_nxt   = open_ang_r;
    last_ang_nxt   = last_ang_r;
    pend_obj_nxt   = pend_obj_r;
    pend_start_nxt = pend_start_r;
    pend_end_nxt   = pend_end_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    dsr_nxt        = dsr_r;
    quo_nxt        = quo_r;
    dcnt_nxt       = dcnt_r;
    dzero_nxt      = dzero_r;
    ovld_nxt       = ovld_r && !out_xfer;
    oobj_nxt       = oobj_r;
    ostart_nxt     = ostart_r;
    oend_nxt       = oend_r;
    omean_nxt      = omean_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        sos_pkg::CFG_MODE:  mode_nxt  = cfg_data[0];
        sos_pkg::CFG_ENTER: enter_nxt = cfg_data;
        sos_pkg::CFG_EXIT:  exit_nxt  = cfg_data;
        sos_pkg::CFG_TOL:   tol_nxt   = cfg_data;
        default:            mode_nxt  = mode_r;
      endcase
    end

    // sample step: sweep clear, open, close, accumulate
    open0  = in_sweep_start ? 1'b0 : open_r;
    cnt0   = in_sweep_start ? '0 : count_r;
    diff   = (in_ir_range > in_sonar_range) ? (in_ir_range - in_sonar_range)
                                            : (in_sonar_range - in_ir_range);
    if (mode_r == sos_pkg::MODE_AGREE) begin
      want_open  = (diff <= tol_r);
      want_close = (diff > tol_r);
    end else begin
      want_open  = (in_ir_range < enter_r);
      want_close = (in_ir_range > exit_r);
    end
    do_open = want_open && !open0 && (cnt0 < CNT_W'(MAX_OBJECTS));
    open1   = open0 || do_open;
    cnt1    = do_open ? cnt0 + CNT_W'(1) : cnt0;
    sum1    = (in_sweep_start || do_open) ? '0 : sum_r;
    tally1  = (in_sweep_start || do_open) ? '0 : tally_r;
    closed  = want_close && open1;
    open2   = open1 && !closed;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          open_nxt     = open2;
          count_nxt    = cnt1;
          last_ang_nxt = in_angle;
          if (do_open) begin
            open_ang_nxt = in_angle;
          end
          if (closed) begin
            sum_nxt        = '0;
            tally_nxt      = '0;
            pend_obj_nxt   = OW'(cnt1);
            pend_start_nxt = do_open ? in_angle : open_ang_r;
            pend_end_nxt   = (mode_r == sos_pkg::MODE_AGREE) ? last_ang_r : in_angle;
            dvd_nxt        = sum1;
            rem_nxt        = '0;
            dsr_nxt        = tally1;
            quo_nxt        = '0;
            dzero_nxt      = (tally1 == '0);
            dcnt_nxt       = DCNT_W'(SUM_W);
            state_nxt      = ST_DIV;
          end else if (open2 && (tally1 < TALLY_W'(MAX_RUN))) begin
            sum_nxt   = sum1 + SUM_W'(in_sonar_range);
            tally_nxt = tally1 + TALLY_W'(1);
          end else begin
            sum_nxt   = sum1;
            tally_nxt = tally1;
          end
        end
      end
      ST_DIV: begin
        rem_nxt  = trial_ge ? TALLY_W'(trial - {1'b0, dsr_r}) : trial[TALLY_W-1:0];
        quo_nxt  = {quo_r[RW-2:0], trial_ge};
        dvd_nxt  = {dvd_r[SUM_W-2:0], 1'b0};
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (dcnt_r == DCNT_W'(1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // load once the output register is free or drains this cycle
        if (!ovld_r || out_xfer) begin
          ovld_nxt   = 1'b1;
          oobj_nxt   = pend_obj_r;
          ostart_nxt = pend_start_r;
          oend_nxt   = pend_end_r;
          omean_nxt  = dzero_r ? '0 : quo_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      mode_r     <= sos_pkg::MODE_THRESH;
      enter_r    <= sos_pkg::RST_ENTER_LEVEL;
      exit_r     <= sos_pkg::RST_EXIT_LEVEL;
      tol_r      <= sos_pkg::RST_AGREE_TOL;
      open_r     <= 1'b0;
      count_r    <= '0;
      sum_r      <= '0;
      tally_r    <= '0;
      open_ang_r <= '0;
      last_ang_r <= '0;
      dcnt_r     <= '0;
      ovld_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      enter_r    <= enter_nxt;
      exit_r     <= exit_nxt;
      tol_r      <= tol_nxt;
      open_r     <= open_nxt;
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      tally_r    <= tally_nxt;
      open_ang_r <= open_ang_nxt;
      last_ang_r <= last_ang_nxt;
      dcnt_r     <= dcnt_nxt;
      ovld_r     <= ovld_nxt;
    end
    pend_obj_r   <= pend_obj_nxt;
    pend_start_r <= pend_start_nxt;
    pend_end_r   <= pend_end_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    dsr_r        <= dsr_nxt;
    quo_r        <= quo_nxt;
    dzero_r      <= dzero_nxt;
    oobj_r       <= oobj_nxt;
    ostart_r     <= ostart_nxt;
    oend_r       <= oend_nxt;
    omean_r      <= omean_nxt;
  end

endmodule

// ===== sv/sos_chk.sv =====
// Port-level checker for the scan object segmenter, bound to the top level.
module sos_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_sweep_start,
  input logic [sos_pkg::RANGE_W-1:0]  in_ir_range,
  input logic [sos_pkg::RANGE_W-1:0]  in_sonar_range,
  input logic [sos_pkg::ANGLE_W-1:0]  in_angle,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [sos_pkg::OBJ_W-1:0]    out_object_number,
  input logic [sos_pkg::ANGLE_W-1:0]  out_start_angle,
  input logic [sos_pkg::ANGLE_W-1:0]  out_end_angle,
  input logic [sos_pkg::RANGE_W-1:0]  out_mean_range,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [sos_pkg::CIDX_W-1:0]   cfg_index,
  input logic [sos_pkg::RANGE_W-1:0]  cfg_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable({out_object_number, out_start_angle,
                                        out_end_angle, out_mean_range}))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // a new result comes only out of the divider, while samples are held off
  a_result_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a division");

endmodule

bind scan_object_segmenter sos_chk u_sos_chk (.*);
